// ===== src/ncs_pkg.sv =====
// shared types, constants and sine table function for the nco frequency shifter
package ncs_pkg;

	localparam int SAMPLE_W = 15;
	localparam int PHASE_W  = 40;
	localparam int FREQ_W   = 33;

	localparam longint unsigned PIH_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic                       flag;
		logic                       last;
	} samp_t;

	// rounded quarter-wave sine entry, evaluated at elaboration
	function automatic longint unsigned sine_entry(int unsigned i, int unsigned qlog,
			int unsigned amp_bits);
		longint unsigned amp;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned s;
		longint unsigned v;
		longint          sum;
		amp  = (64'd1 << amp_bits) - 64'd1;
		x    = (PIH_Q30 * (64'(i) * 64'd2 + 64'd1)) >> (qlog + 1);
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		// taylor series, terms truncated in q30
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		s = longint'(sum);
		if (s > ONE_Q30) begin
			s = ONE_Q30;
		end
		v = (s * amp + (ONE_Q30 >> 1)) >> 30;
		if (v > amp) begin
			v = amp;
		end
		return v;
	endfunction

endpackage

// ===== src/ncs_stream_if.sv =====
// request channel interfaces for sample input and shifted output
interface ncs_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ncs_pkg::SAMPLE_W-1:0] re_sample;
	logic signed [ncs_pkg::SAMPLE_W-1:0] im_sample;
	logic                                side_flag;
	logic                                frame_end;

	modport source (output valid, re_sample, im_sample, side_flag, frame_end, input ready);
	modport sink (input valid, re_sample, im_sample, side_flag, frame_end, output ready);
endinterface

interface ncs_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ncs_pkg::SAMPLE_W-1:0] re_out;
	logic signed [ncs_pkg::SAMPLE_W-1:0] im_out;
	logic                                flag_out;
	logic                                last_out;

	modport source (output valid, re_out, im_out, flag_out, last_out, input ready);
	modport sink (input valid, re_out, im_out, flag_out, last_out, output ready);
endinterface

// ===== src/ncs_phase.sv =====
// phase accumulator and input sample register
module ncs_phase (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                freq_we,
	input  logic signed [ncs_pkg::FREQ_W-1:0]   freq_word,
	ncs_in_if.sink                              in_chan,
	input  logic                                ready_next,
	output logic                                valid_s1,
	output logic        [ncs_pkg::PHASE_W-1:0]  phase_s1,
	output ncs_pkg::samp_t                      samp_s1
);

	logic signed [ncs_pkg::FREQ_W-1:0]  freq_q;
	logic        [ncs_pkg::PHASE_W-1:0] acc_q;
	logic                               valid_q;
	logic                               ready_s1;
	logic                               accept;
	ncs_pkg::samp_t                     samp_q;

	assign ready_s1       = !valid_q || ready_next;
	assign in_chan.ready  = ready_s1;
	assign accept         = in_chan.valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
		end else if (freq_we) begin
			freq_q <= freq_word;
		end
	end

	// the accumulator only moves when a new request enters, so it is the phase of stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_q <= in_chan.valid;
			end
			if (accept) begin
				acc_q <= acc_q + ncs_pkg::PHASE_W'(freq_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= '{re: in_chan.re_sample, im: in_chan.im_sample,
				flag: in_chan.side_flag, last: in_chan.frame_end};
		end
	end

	assign valid_s1 = valid_q;
	assign phase_s1 = acc_q;
	assign samp_s1  = samp_q;

endmodule

// ===== src/ncs_sincos.sv =====
// quarter-wave sine lookup with quadrant mapping
module ncs_sincos #(
	parameter int PHASE_INDEX_BITS = 10,
	parameter int SINE_BITS        = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s1,
	input  logic        [ncs_pkg::PHASE_W-1:0] phase_s1,
	input  ncs_pkg::samp_t                     samp_s1,
	input  logic                               ready_next,
	output logic                               ready_s2,
	output logic                               valid_s2,
	output logic signed [SINE_BITS:0]          sin_s2,
	output logic signed [SINE_BITS:0]          cos_s2,
	output ncs_pkg::samp_t                     samp_s2
);

	localparam int IDX_W = PHASE_INDEX_BITS - 2;
	localparam int QSIZE = 1 << IDX_W;

	logic        [SINE_BITS-1:0] sine_rom [QSIZE];
	logic        [IDX_W-1:0]     idx;
	logic signed [SINE_BITS:0]   t1;
	logic signed [SINE_BITS:0]   t2;
	logic signed [SINE_BITS:0]   sin_d;
	logic signed [SINE_BITS:0]   cos_d;
	logic                        valid_q;

	for (genvar g = 0; g < QSIZE; g++) begin : g_rom
		assign sine_rom[g] = SINE_BITS'(ncs_pkg::sine_entry(g, IDX_W, SINE_BITS));
	end

	assign idx = phase_s1[ncs_pkg::PHASE_W-3 -: IDX_W];
	// mirrored entry gives the cosine
	assign t1  = {1'b0, sine_rom[idx]};
	assign t2  = {1'b0, sine_rom[~idx]};

	always_comb begin
		case (ncs_pkg::quad_t'(phase_s1[ncs_pkg::PHASE_W-1 -: 2]))
			ncs_pkg::QUAD_0: begin
				sin_d = t1;
				cos_d = t2;
			end
			ncs_pkg::QUAD_1: begin
				sin_d = t2;
				cos_d = -t1;
			end
			ncs_pkg::QUAD_2: begin
				sin_d = -t1;
				cos_d = -t2;
			end
			default: begin
				sin_d = -t2;
				cos_d = t1;
			end
		endcase
	end

	assign ready_s2 = !valid_q || ready_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_s2) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			sin_s2  <= sin_d;
			cos_s2  <= cos_d;
			samp_s2 <= samp_s1;
		end
	end

	assign valid_s2 = valid_q;

endmodule

// ===== src/ncs_rot.sv =====
// complex rotation by the nco phasor and output register
module ncs_rot #(
	parameter int SINE_BITS = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s2,
	input  logic signed [SINE_BITS:0] sin_s2,
	input  logic signed [SINE_BITS:0] cos_s2,
	input  ncs_pkg::samp_t            samp_s2,
	output logic                      ready_s3,
	ncs_out_if.source                 out_chan
);

	localparam int PROD_W = SINE_BITS + 1 + ncs_pkg::SAMPLE_W;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [PROD_W-1:0]           cre;
	logic signed [PROD_W-1:0]           sim;
	logic signed [PROD_W-1:0]           cim;
	logic signed [PROD_W-1:0]           sre;
	logic signed [SUM_W-1:0]            yi;
	logic signed [SUM_W-1:0]            yq;
	logic                               valid_q;
	logic signed [ncs_pkg::SAMPLE_W-1:0] re_q;
	logic signed [ncs_pkg::SAMPLE_W-1:0] im_q;
	logic                               flag_q;
	logic                               last_q;

	// multiply by exp(-j*phase)
	assign cre = cos_s2 * samp_s2.re;
	assign sim = sin_s2 * samp_s2.im;
	assign cim = cos_s2 * samp_s2.im;
	assign sre = sin_s2 * samp_s2.re;
	assign yi  = SUM_W'(cre) + SUM_W'(sim);
	assign yq  = SUM_W'(cim) - SUM_W'(sre);

	assign ready_s3 = !valid_q || out_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_s3) begin
			valid_q <= valid_s2;
		end
	end

	// arithmetic shift by the sine width, then wrap to the sample width
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			re_q   <= yi[SINE_BITS +: ncs_pkg::SAMPLE_W];
			im_q   <= yq[SINE_BITS +: ncs_pkg::SAMPLE_W];
			flag_q <= samp_s2.flag;
			last_q <= samp_s2.last;
		end
	end

	assign out_chan.valid    = valid_q;
	assign out_chan.re_out   = re_q;
	assign out_chan.im_out   = im_q;
	assign out_chan.flag_out = flag_q;
	assign out_chan.last_out = last_q;

endmodule

// ===== src/nco_complex_frequency_shifter.sv =====
// top level of the nco complex frequency shifter
//
//   channel    dir   handshake            payload
//   in_chan    in    valid / ready        re_sample, im_sample, side_flag, frame_end
//   out_chan   out   valid / ready        re_out, im_out, flag_out, last_out
//   freq       in    freq_we              freq_word
//
// one request per cycle while out_chan.ready is high; out_chan.valid is registered
// stages: phase accumulate, sine rom lookup, complex multiply into the output register
// each stage holds its request while the next one is full, bubbles collapse
// arst_n clears the accumulator, the frequency word and all valid bits
// freq_word is taken on any cycle with freq_we high
module nco_complex_frequency_shifter #(
	parameter int PHASE_INDEX_BITS = 10,
	parameter int SINE_BITS        = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              freq_we,
	input  logic signed [ncs_pkg::FREQ_W-1:0] freq_word,
	ncs_in_if.sink                            in_chan,
	ncs_out_if.source                         out_chan
);

	logic                               valid_s1;
	logic        [ncs_pkg::PHASE_W-1:0] phase_s1;
	ncs_pkg::samp_t                     samp_s1;
	logic                               ready_s2;
	logic                               valid_s2;
	logic signed [SINE_BITS:0]          sin_s2;
	logic signed [SINE_BITS:0]          cos_s2;
	ncs_pkg::samp_t                     samp_s2;
	logic                               ready_s3;

	ncs_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.freq_we    (freq_we),
		.freq_word  (freq_word),
		.in_chan    (in_chan),
		.ready_next (ready_s2),
		.valid_s1   (valid_s1),
		.phase_s1   (phase_s1),
		.samp_s1    (samp_s1)
	);

	ncs_sincos #(
		.PHASE_INDEX_BITS (PHASE_INDEX_BITS),
		.SINE_BITS        (SINE_BITS)
	) u_sincos (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.phase_s1   (phase_s1),
		.samp_s1    (samp_s1),
		.ready_next (ready_s3),
		.ready_s2   (ready_s2),
		.valid_s2   (valid_s2),
		.sin_s2     (sin_s2),
		.cos_s2     (cos_s2),
		.samp_s2    (samp_s2)
	);

	ncs_rot #(
		.SINE_BITS (SINE_BITS)
	) u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.sin_s2   (sin_s2),
		.cos_s2   (cos_s2),
		.samp_s2  (samp_s2),
		.ready_s3 (ready_s3),
		.out_chan (out_chan)
	);

endmodule

// ===== src/ncs_checker.sv =====
// port-level checks for the nco frequency shifter, bound to the top level
module ncs_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [ncs_pkg::SAMPLE_W-1:0] re_out,
	input logic signed [ncs_pkg::SAMPLE_W-1:0] im_out,
	input logic                                flag_out,
	input logic                                last_out
);

	logic [2:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(re_out) && $stable(im_out)
			&& $stable(flag_out) && $stable(last_out))
		else $error("output payload changed while stalled");

	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more requests in flight than pipeline stages");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("output request without an accepted input");

endmodule

bind nco_complex_frequency_shifter ncs_checker u_ncs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_chan.valid),
	.in_ready  (in_chan.ready),
	.out_valid (out_chan.valid),
	.out_ready (out_chan.ready),
	.re_out    (out_chan.re_out),
	.im_out    (out_chan.im_out),
	.flag_out  (out_chan.flag_out),
	.last_out  (out_chan.last_out)
);
